### src/csic_pkg.sv
// ============================================================================
// csic_pkg
// Shared widths, register indexes, state codes and queue word types for the
// shard index compactor.
// ============================================================================
package csic_pkg;

    localparam int IN_W       = 32;
    localparam int IDX_W      = 31;
    localparam int IL_W       = 16;
    localparam int GS_W       = 9;
    localparam int RANK_W     = 8;
    localparam int SLOT_W     = 12;
    localparam int COUNT_W    = 13;
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 16;

    localparam int DEF_MAX_ROW_WIDTH = 4096;
    localparam int DEF_QUEUE_DEPTH   = 2;

    localparam logic [CFG_ADDR_W-1:0] CFG_OWNER_RANK = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_GROUP_SIZE = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_INTERLEAVE = 2'd2;

    localparam logic [RANK_W-1:0] RST_OWNER_RANK = 8'd0;
    localparam logic [GS_W-1:0]   RST_GROUP_SIZE = 9'd1;
    localparam logic [IL_W-1:0]   RST_INTERLEAVE = 16'd1;

    typedef enum logic [2:0] {
        FS_IDLE,
        FS_DIV_IL,
        FS_DIV_GS,
        FS_MUL,
        FS_SEND
    } t_front_state;

    typedef struct packed {
        logic             keep;
        logic             last;
        logic [IDX_W-1:0] local_index;
    } t_mid_word;

    typedef struct packed {
        logic               is_row_end;
        logic [SLOT_W-1:0]  slot;
        logic [IDX_W-1:0]   local_index;
        logic [COUNT_W-1:0] kept_count;
    } t_res_word;

endpackage

### src/csic_div.sv
// ============================================================================
// csic_div
// Radix-2 restoring divider, one quotient bit per cycle, shared by both
// divisions of the front end.
// ============================================================================
module csic_div (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [csic_pkg::IDX_W-1:0] i_dividend,
    input  logic [csic_pkg::IL_W-1:0]  i_divisor,
    output logic                      o_done,
    output logic [csic_pkg::IDX_W-1:0] o_quo,
    output logic [csic_pkg::IL_W-1:0]  o_rem
);
    import csic_pkg::*;

    localparam int CNT_W = $clog2(IDX_W + 1);

    logic [IL_W-1:0]  r_rem, n_rem;
    logic [IDX_W-1:0] r_quo;
    logic [IL_W-1:0]  r_div;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;

    logic [IL_W:0] w_shift;
    logic [IL_W:0] w_sub;
    logic          w_ge;

    always_comb begin
        w_shift = {r_rem, r_quo[IDX_W-1]};
        w_ge    = w_shift >= {1'b0, r_div};
        w_sub   = w_shift - {1'b0, r_div};
        n_rem   = w_ge ? w_sub[IL_W-1:0] : w_shift[IL_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(IDX_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_quo <= {r_quo[IDX_W-2:0], w_ge};
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;
    assign o_rem  = r_rem;

endmodule

### src/csic_fifo.sv
// ============================================================================
// csic_fifo
// Small register queue with push/full and pop/empty sides.
// ============================================================================
module csic_fifo #(
    parameter int W     = 8,
    parameter int DEPTH = csic_pkg::DEF_QUEUE_DEPTH
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic [W-1:0] i_data,
    output logic         o_full,
    input  logic         i_pop,
    output logic [W-1:0] o_data,
    output logic         o_empty
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [W-1:0]     r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr, r_rd;
    logic [CNT_W-1:0] r_cnt;
    logic             w_do_push, w_do_pop;

    assign o_full    = (r_cnt == CNT_W'(DEPTH));
    assign o_empty   = (r_cnt == '0);
    assign w_do_push = i_push && !o_full;
    assign w_do_pop  = i_pop && !o_empty;
    assign o_data    = r_mem[r_rd];

    function automatic logic [PTR_W-1:0] f_wrap(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_do_push) r_wr <= f_wrap(r_wr);
            if (w_do_pop)  r_rd <= f_wrap(r_rd);
            if (w_do_push && !w_do_pop)      r_cnt <= r_cnt + 1'b1;
            else if (w_do_pop && !w_do_push) r_cnt <= r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_do_push) r_mem[r_wr] <= i_data;
    end

endmodule

### src/csic_front.sv
// ============================================================================
// csic_front
// Accept one index, map a nonnegative one onto this shard through two
// divisions and one multiply, and hand a classified word to the middle queue.
// ============================================================================
module csic_front (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_push,
    input  logic [csic_pkg::IN_W-1:0]   i_global_index,
    input  logic                        i_last_in_row,
    output logic                        o_busy,
    input  logic [csic_pkg::RANK_W-1:0] i_owner_rank,
    input  logic [csic_pkg::GS_W-1:0]   i_group_size,
    input  logic [csic_pkg::IL_W-1:0]   i_interleave,
    output logic                        o_mid_push,
    output csic_pkg::t_mid_word         o_mid_word,
    input  logic                        i_mid_full
);
    import csic_pkg::*;

    t_front_state r_state, n_state;

    logic              r_last;
    logic              r_keep;
    logic [IL_W-1:0]   r_within;
    logic [IDX_W-1:0]  r_quo2;
    logic [IDX_W+IL_W-1:0] r_prod;

    logic              w_accept;
    logic              w_div_start;
    logic [IDX_W-1:0]  w_div_dividend;
    logic [IL_W-1:0]   w_div_divisor;
    logic              w_div_done;
    logic [IDX_W-1:0]  w_div_quo;
    logic [IL_W-1:0]   w_div_rem;

    assign w_accept = i_push && (r_state == FS_IDLE);

    csic_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_div_dividend),
        .i_divisor  (w_div_divisor),
        .o_done     (w_div_done),
        .o_quo      (w_div_quo),
        .o_rem      (w_div_rem)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            FS_IDLE: begin
                if (w_accept) n_state = i_global_index[IN_W-1] ? FS_SEND : FS_DIV_IL;
            end
            FS_DIV_IL: if (w_div_done) n_state = FS_DIV_GS;
            FS_DIV_GS: if (w_div_done) n_state = FS_MUL;
            FS_MUL:    n_state = FS_SEND;
            FS_SEND:   if (!i_mid_full) n_state = FS_IDLE;
            default:   n_state = FS_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        w_div_start    = 1'b0;
        w_div_dividend = i_global_index[IDX_W-1:0];
        w_div_divisor  = i_interleave;
        o_mid_push     = 1'b0;
        o_busy         = 1'b1;
        case (r_state)
            FS_IDLE: begin
                o_busy      = 1'b0;
                w_div_start = w_accept && !i_global_index[IN_W-1];
            end
            FS_DIV_IL: begin
                w_div_start    = w_div_done;
                w_div_dividend = w_div_quo;
                w_div_divisor  = IL_W'(i_group_size);
            end
            FS_SEND: o_mid_push = 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= FS_IDLE;
        else          r_state <= n_state;
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_last <= i_last_in_row;
            r_keep <= 1'b0;
        end
        if (r_state == FS_DIV_IL && w_div_done) r_within <= w_div_rem;
        if (r_state == FS_DIV_GS && w_div_done) begin
            r_quo2 <= w_div_quo;
            r_keep <= (w_div_rem == IL_W'(i_owner_rank));
        end
        if (r_state == FS_MUL) r_prod <= r_quo2 * i_interleave;
    end

    always_comb begin
        o_mid_word.keep        = r_keep;
        o_mid_word.last        = r_last;
        o_mid_word.local_index = r_prod[IDX_W-1:0] + IDX_W'(r_within);
    end

endmodule

### src/csic_back.sv
// ============================================================================
// csic_back
// Row slot counter: assign compacted slots, drop entries past the row limit
// and emit the row end marker.
// ============================================================================
module csic_back #(
    parameter int MAX_ROW_WIDTH = csic_pkg::DEF_MAX_ROW_WIDTH
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_mid_empty,
    input  csic_pkg::t_mid_word i_mid_word,
    output logic                o_mid_pop,
    input  logic                i_res_full,
    output logic                o_res_push,
    output csic_pkg::t_res_word o_res_word
);
    import csic_pkg::*;

    localparam int CNT_W = $clog2(MAX_ROW_WIDTH + 1);

    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_kept_sent, n_kept_sent;
    logic [31:0]      w_cnt32;
    logic             w_room;
    logic             w_go;
    logic             w_push_kept;
    logic             w_push_end;

    assign w_cnt32 = 32'(r_cnt);
    assign w_room  = w_cnt32 < 32'(MAX_ROW_WIDTH);
    assign w_go    = !i_mid_empty && !i_res_full;

    always_comb begin
        n_cnt       = r_cnt;
        n_kept_sent = r_kept_sent;
        w_push_kept = 1'b0;
        w_push_end  = 1'b0;
        o_mid_pop   = 1'b0;
        if (w_go) begin
            if (!r_kept_sent && i_mid_word.keep && w_room) begin
                // kept entry first; hold the word if a marker still follows
                w_push_kept = 1'b1;
                n_cnt       = r_cnt + 1'b1;
                if (i_mid_word.last) n_kept_sent = 1'b1;
                else                 o_mid_pop   = 1'b1;
            end else if (i_mid_word.last) begin
                w_push_end  = 1'b1;
                n_cnt       = '0;
                n_kept_sent = 1'b0;
                o_mid_pop   = 1'b1;
            end else begin
                // dropped or negative entry: nothing to emit
                o_mid_pop = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt       <= '0;
            r_kept_sent <= 1'b0;
        end else begin
            r_cnt       <= n_cnt;
            r_kept_sent <= n_kept_sent;
        end
    end

    assign o_res_push = w_push_kept || w_push_end;

    always_comb begin
        o_res_word.is_row_end  = w_push_end;
        o_res_word.slot        = w_push_end ? '0 : w_cnt32[SLOT_W-1:0];
        o_res_word.local_index = w_push_end ? '0 : i_mid_word.local_index;
        o_res_word.kept_count  = w_push_end ? w_cnt32[COUNT_W-1:0]
                                            : COUNT_W'(w_cnt32 + 32'd1);
    end

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cnt32 <= 32'(MAX_ROW_WIDTH))
        else $error("row count above limit");

    a_end_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push_end |=> (r_cnt == '0) && !r_kept_sent)
        else $error("row end did not clear count");

    a_kept_incr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push_kept |=> (r_cnt == $past(r_cnt) + 1'b1))
        else $error("kept entry did not advance count");

    a_no_double: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_push && r_kept_sent) |-> w_push_end)
        else $error("second kept entry for one word");

endmodule

### src/context_shard_index_compactor_unit.sv
// ============================================================================
// context_shard_index_compactor_unit
// Maps a stream of global indices onto this shard and compacts kept entries.
// ============================================================================
// Usage:
//   Input side is a queue: drive i_global_index / i_last_in_row with push;
//   the word is taken on a clock edge with push high and full low.
//   Result side is a queue: while empty is low the oldest result sits on
//   o_is_row_end / o_slot / o_local_index / o_kept_count; pop takes it.
//   The user writes registers (owner rank, group size, interleave) through
//   i_cfg_we / i_cfg_addr / i_cfg_wdata only while the block is idle; the
//   block itself does not enforce this.
// Sequence:
//   A nonnegative index runs two 31-step divisions on the shared radix-2
//   divider, then one multiply and a hand-off; full stays high until the
//   hand-off is taken. A negative index skips straight to the hand-off. The
//   back end emits a kept entry and a row marker from one word as two results.
// Reset: synchronous, active low; clears both queues, the row count and the
//   front sequencer, and restores register defaults.
// Stall: a stalled receiver fills the result queue, then the middle queue,
//   then full holds off new words. Nothing is dropped.
// ============================================================================
module context_shard_index_compactor_unit #(
    parameter int MAX_ROW_WIDTH = csic_pkg::DEF_MAX_ROW_WIDTH
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            push,
    output logic                            full,
    input  logic [csic_pkg::IN_W-1:0]       i_global_index,
    input  logic                            i_last_in_row,
    output logic                            empty,
    input  logic                            pop,
    output logic                            o_is_row_end,
    output logic [csic_pkg::SLOT_W-1:0]     o_slot,
    output logic [csic_pkg::IDX_W-1:0]      o_local_index,
    output logic [csic_pkg::COUNT_W-1:0]    o_kept_count,
    input  logic                            i_cfg_we,
    input  logic [csic_pkg::CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [csic_pkg::CFG_DATA_W-1:0] i_cfg_wdata
);
    import csic_pkg::*;

    localparam int MID_W = $bits(t_mid_word);
    localparam int RES_W = $bits(t_res_word);

    // configuration registers
    logic [RANK_W-1:0] r_owner_rank;
    logic [GS_W-1:0]   r_group_size;
    logic [IL_W-1:0]   r_interleave;
    logic [GS_W-1:0]   w_gs_eff;
    logic [IL_W-1:0]   w_il_eff;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_owner_rank <= RST_OWNER_RANK;
            r_group_size <= RST_GROUP_SIZE;
            r_interleave <= RST_INTERLEAVE;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_OWNER_RANK: r_owner_rank <= i_cfg_wdata[RANK_W-1:0];
                CFG_GROUP_SIZE: r_group_size <= i_cfg_wdata[GS_W-1:0];
                CFG_INTERLEAVE: r_interleave <= i_cfg_wdata[IL_W-1:0];
                default: ;  // drop writes to unused indexes
            endcase
        end
    end

    // a zero group size or interleave behaves as one
    assign w_gs_eff = (r_group_size == '0) ? GS_W'(1) : r_group_size;
    assign w_il_eff = (r_interleave == '0) ? IL_W'(1) : r_interleave;

    // front end
    logic       w_front_busy;
    logic       w_mid_push;
    t_mid_word  w_mid_in;
    logic       w_mid_full;

    assign full = w_front_busy;

    csic_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_push         (push),
        .i_global_index (i_global_index),
        .i_last_in_row  (i_last_in_row),
        .o_busy         (w_front_busy),
        .i_owner_rank   (r_owner_rank),
        .i_group_size   (w_gs_eff),
        .i_interleave   (w_il_eff),
        .o_mid_push     (w_mid_push),
        .o_mid_word     (w_mid_in),
        .i_mid_full     (w_mid_full)
    );

    // queue between front and back ends
    logic [MID_W-1:0] w_mid_bits;
    logic             w_mid_empty;
    logic             w_mid_pop;
    t_mid_word        w_mid_out;

    csic_fifo #(.W(MID_W), .DEPTH(DEF_QUEUE_DEPTH)) u_mid_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_mid_push),
        .i_data  (w_mid_in),
        .o_full  (w_mid_full),
        .i_pop   (w_mid_pop),
        .o_data  (w_mid_bits),
        .o_empty (w_mid_empty)
    );

    assign w_mid_out = t_mid_word'(w_mid_bits);

    // back end: slot counter
    logic      w_res_push;
    logic      w_res_full;
    t_res_word w_res_in;

    csic_back #(.MAX_ROW_WIDTH(MAX_ROW_WIDTH)) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_mid_empty (w_mid_empty),
        .i_mid_word  (w_mid_out),
        .o_mid_pop   (w_mid_pop),
        .i_res_full  (w_res_full),
        .o_res_push  (w_res_push),
        .o_res_word  (w_res_in)
    );

    // result queue parts the back end from the receiver
    logic [RES_W-1:0] w_res_bits;
    t_res_word        w_res_out;

    csic_fifo #(.W(RES_W), .DEPTH(DEF_QUEUE_DEPTH)) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_res_push),
        .i_data  (w_res_in),
        .o_full  (w_res_full),
        .i_pop   (pop),
        .o_data  (w_res_bits),
        .o_empty (empty)
    );

    assign w_res_out     = t_res_word'(w_res_bits);
    assign o_is_row_end  = w_res_out.is_row_end;
    assign o_slot        = w_res_out.slot;
    assign o_local_index = w_res_out.local_index;
    assign o_kept_count  = w_res_out.kept_count;

endmodule
